// ===== rtl/ccpc_pkg.sv =====
// Shared types and constants for the character-cell pixel compositor.
// Holds the input and result word layouts, item kind codes, register
// indexes, reset values and the palette lookup. No dependencies.
package ccpc_pkg;

    // One input word: a render request or a memory write.
    typedef struct packed {
        logic [2:0]  kind;
        logic [12:0] mem_address;
        logic [7:0]  write_byte;
        logic [7:0]  char_code;
        logic [7:0]  attribute;
        logic [7:0]  pcg_code_low;
        logic [7:0]  pcg_control;
        logic [2:0]  cell_line;
    } in_word_t;

    // One result word: a single pixel of the cell line.
    typedef struct packed {
        logic [2:0] pixel_color;
        logic       last_pixel;
    } out_word_t;

    // Item kinds. The remaining codes are accepted and dropped.
    localparam logic [2:0] KIND_RENDER   = 3'd0;
    localparam logic [2:0] KIND_WR_CG    = 3'd1;
    localparam logic [2:0] KIND_WR_PCG0  = 3'd2;
    localparam logic [2:0] KIND_WR_PCG1  = 3'd3;
    localparam logic [2:0] KIND_WR_PCG2  = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODE_700     = 2'd0;
    localparam logic [1:0] REG_PRIORITY_BFP = 2'd1;
    localparam logic [1:0] REG_TEXT_PALETTE = 2'd2;
    localparam logic [1:0] REG_PCG_PALETTE  = 2'd3;

    localparam int          CFG_WIDTH         = 24;
    localparam int          PIX_PER_CELL      = 8;
    localparam logic [23:0] PCG_PALETTE_RESET = 24'd16434824;

    // Attribute and control byte fields.
    localparam int ATTR_GROUP_BIT = 7;
    localparam int PCG_ENABLE_BIT = 3;

    // Pick 3-bit color entry idx out of a packed eight-entry palette.
    function automatic logic [2:0] palette_entry(input logic [23:0] pal,
                                                 input logic [2:0]  idx);
        logic [4:0] base;
        base = 5'(idx) * 5'd3;
        return pal[base +: 3];
    endfunction

endpackage

// ===== rtl/char_cell_pcg_pixel_compositor_unit.sv =====
// Top level of the character-cell pixel compositor: CG and PCG plane
// memories, a three-stage render pipeline and the pixel serializer.
// Depends on ccpc_pkg.
//
// Usage:
//   Input words arrive on s_valid/s_ready/s_data. Kind 1 writes a CG byte,
//   kinds 2 to 4 write a byte of PCG plane 0 to 2; writes at addresses past
//   a memory's depth are dropped. Kind 0 renders one line of a text cell and
//   yields eight pixel words on m_valid/m_ready/m_data, left to right, with
//   last_pixel set on the eighth. Other kinds are taken and dropped. The
//   user must write the configuration registers via cfg_wr_en, cfg_index
//   and cfg_wdata, one per cycle, while idle; the block does not enforce it.
// Timing:
//   A render word passes the input, memory read, composed-line and
//   serializer registers before its first pixel is shown. Render words are
//   paced by the single pixel output port, which sends a cell's pixels one
//   at a time; write words go one per cycle when the pipeline ahead of them
//   is free. A new word is taken while the current cell is still being sent.
// Reset and stalls:
//   Reset empties the pipeline and restores the register defaults; memory
//   contents are undefined until written. When m_ready is low the current
//   pixel holds and the stages behind fill up, then s_ready drops.
module char_cell_pcg_pixel_compositor_unit #(
    parameter int CG_DEPTH  = 4096,
    parameter int PCG_DEPTH = 8192
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ccpc_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ccpc_pkg::out_word_t  m_data,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [ccpc_pkg::CFG_WIDTH-1:0] cfg_wdata
);

    localparam int CG_AW  = $clog2(CG_DEPTH);
    localparam int PCG_AW = $clog2(PCG_DEPTH);

    // Configuration registers.
    logic        mode_700_reg;
    logic        priority_bfp_reg;
    logic [23:0] text_palette_reg;
    logic [23:0] pcg_palette_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_700_reg     <= 1'b0;
            priority_bfp_reg <= 1'b0;
            text_palette_reg <= '0;
            pcg_palette_reg  <= ccpc_pkg::PCG_PALETTE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ccpc_pkg::REG_MODE_700:     mode_700_reg     <= cfg_wdata[0];
                ccpc_pkg::REG_PRIORITY_BFP: priority_bfp_reg <= cfg_wdata[0];
                ccpc_pkg::REG_TEXT_PALETTE: text_palette_reg <= cfg_wdata;
                ccpc_pkg::REG_PCG_PALETTE:  pcg_palette_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline handshake: each stage loads when empty or when it drains.
    logic                s1_valid_reg;
    ccpc_pkg::in_word_t  s1_data_reg;
    logic                s2_valid_reg;
    logic                s3_valid_reg;
    logic                ser_valid_reg;
    logic [2:0]          ser_cnt_reg;
    logic                ser_last;
    logic                ser_load;
    logic                s3_ready;
    logic                s2_ready;
    logic                s1_fire;

    assign ser_last = (ser_cnt_reg == 3'(ccpc_pkg::PIX_PER_CELL - 1));
    assign ser_load = s3_valid_reg && (!ser_valid_reg || (m_ready && ser_last));
    assign s3_ready = !s3_valid_reg || ser_load;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_fire  = s1_valid_reg && s2_ready;
    assign s_ready  = !s1_valid_reg || s2_ready;

    // Stage 1: input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_data_reg <= s_data;
        end
    end

    // Stage 1 address and control decode.
    logic        s1_render;
    logic [11:0] cg_rd_addr;
    logic [12:0] pcg_rd_addr;
    logic        cg_rd_ok;
    logic        pcg_rd_ok;
    logic        cg_wr_ok;
    logic        pcg_wr_ok;
    logic        cg_we;
    logic        p0_we;
    logic        p1_we;
    logic        p2_we;
    logic        s1_pcg_on;
    logic [2:0]  s1_fg;
    logic [2:0]  s1_bg;

    assign s1_render   = (s1_data_reg.kind == ccpc_pkg::KIND_RENDER);
    assign cg_rd_addr  = {s1_data_reg.attribute[ccpc_pkg::ATTR_GROUP_BIT],
                          s1_data_reg.char_code, s1_data_reg.cell_line};
    assign pcg_rd_addr = {s1_data_reg.pcg_control[7:6], s1_data_reg.pcg_code_low,
                          s1_data_reg.cell_line};
    assign cg_rd_ok    = ({1'b0, cg_rd_addr} < 13'(CG_DEPTH));
    assign pcg_rd_ok   = ({1'b0, pcg_rd_addr} < 14'(PCG_DEPTH));
    assign cg_wr_ok    = (s1_data_reg.mem_address < 13'(CG_DEPTH));
    assign pcg_wr_ok   = ({1'b0, s1_data_reg.mem_address} < 14'(PCG_DEPTH));
    assign cg_we = s1_fire && cg_wr_ok && (s1_data_reg.kind == ccpc_pkg::KIND_WR_CG);
    assign p0_we = s1_fire && pcg_wr_ok && (s1_data_reg.kind == ccpc_pkg::KIND_WR_PCG0);
    assign p1_we = s1_fire && pcg_wr_ok && (s1_data_reg.kind == ccpc_pkg::KIND_WR_PCG1);
    assign p2_we = s1_fire && pcg_wr_ok && (s1_data_reg.kind == ccpc_pkg::KIND_WR_PCG2);
    assign s1_pcg_on = !mode_700_reg
                       && s1_data_reg.pcg_control[ccpc_pkg::PCG_ENABLE_BIT];
    assign s1_fg = ccpc_pkg::palette_entry(text_palette_reg, s1_data_reg.attribute[6:4]);
    assign s1_bg = ccpc_pkg::palette_entry(text_palette_reg, s1_data_reg.attribute[2:0]);

    // Memories: one write and one registered read per cycle each.
    logic [7:0] cg_mem [CG_DEPTH];
    logic [7:0] p0_mem [PCG_DEPTH];
    logic [7:0] p1_mem [PCG_DEPTH];
    logic [7:0] p2_mem [PCG_DEPTH];
    logic [7:0] cg_q_reg;
    logic [7:0] p0_q_reg;
    logic [7:0] p1_q_reg;
    logic [7:0] p2_q_reg;

    always_ff @(posedge aclk) begin
        if (cg_we) begin
            cg_mem[s1_data_reg.mem_address[CG_AW-1:0]] <= s1_data_reg.write_byte;
        end
        if (s1_fire) begin
            cg_q_reg <= cg_mem[cg_rd_addr[CG_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (p0_we) begin
            p0_mem[s1_data_reg.mem_address[PCG_AW-1:0]] <= s1_data_reg.write_byte;
        end
        if (s1_fire) begin
            p0_q_reg <= p0_mem[pcg_rd_addr[PCG_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_we) begin
            p1_mem[s1_data_reg.mem_address[PCG_AW-1:0]] <= s1_data_reg.write_byte;
        end
        if (s1_fire) begin
            p1_q_reg <= p1_mem[pcg_rd_addr[PCG_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_we) begin
            p2_mem[s1_data_reg.mem_address[PCG_AW-1:0]] <= s1_data_reg.write_byte;
        end
        if (s1_fire) begin
            p2_q_reg <= p2_mem[pcg_rd_addr[PCG_AW-1:0]];
        end
    end

    // Stage 2: render side data that travels with the memory reads.
    logic       s2_pcg_on_reg;
    logic       s2_cg_ok_reg;
    logic       s2_pcg_ok_reg;
    logic [2:0] s2_fg_reg;
    logic [2:0] s2_bg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg && s1_render;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            s2_pcg_on_reg <= s1_pcg_on;
            s2_cg_ok_reg  <= cg_rd_ok;
            s2_pcg_ok_reg <= pcg_rd_ok;
            s2_fg_reg     <= s1_fg;
            s2_bg_reg     <= s1_bg;
        end
    end

    // Stage 2 compose: eight pixels side by side, leftmost in the low bits.
    logic [7:0]  mask;
    logic [7:0]  m0;
    logic [7:0]  m1;
    logic [7:0]  m2;
    logic [23:0] s3_pix_next;

    always_comb begin
        logic       tbit;
        logic [2:0] text;
        logic [2:0] id;
        logic [2:0] pcg_color;
        logic [2:0] color;
        mask = s2_cg_ok_reg  ? cg_q_reg : 8'd0;
        m0   = s2_pcg_ok_reg ? p0_q_reg : 8'd0;
        m1   = s2_pcg_ok_reg ? p1_q_reg : 8'd0;
        m2   = s2_pcg_ok_reg ? p2_q_reg : 8'd0;
        s3_pix_next = '0;
        for (int k = 0; k < ccpc_pkg::PIX_PER_CELL; k++) begin
            tbit      = mask[k];
            text      = tbit ? s2_fg_reg : s2_bg_reg;
            id        = {m2[7-k], m1[7-k], m0[7-k]};
            pcg_color = ccpc_pkg::palette_entry(pcg_palette_reg, id);
            color     = text;
            if (s2_pcg_on_reg) begin
                if (priority_bfp_reg) begin
                    // PCG on top; color id zero lets the text show through.
                    if (id != 3'd0) begin
                        color = pcg_color;
                    end
                end else begin
                    // Foreground over PCG; the background never shows.
                    color = tbit ? s2_fg_reg : pcg_color;
                end
            end
            s3_pix_next[3*k +: 3] = color;
        end
    end

    // Stage 3: composed cell line.
    logic [23:0] s3_pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg && s3_ready) begin
            s3_pix_reg <= s3_pix_next;
        end
    end

    // Serializer: shifts out one pixel per accepted result word.
    logic [23:0] ser_pix_reg;
    logic [23:0] ser_pix_next;
    logic [2:0]  ser_cnt_next;
    logic        ser_valid_next;
    logic        m_fire;

    assign m_fire = ser_valid_reg && m_ready;

    always_comb begin
        ser_pix_next   = ser_pix_reg;
        ser_cnt_next   = ser_cnt_reg;
        ser_valid_next = ser_valid_reg;
        if (ser_load) begin
            ser_pix_next   = s3_pix_reg;
            ser_cnt_next   = 3'd0;
            ser_valid_next = 1'b1;
        end else if (m_fire) begin
            ser_pix_next   = {3'd0, ser_pix_reg[23:3]};
            ser_cnt_next   = ser_cnt_reg + 3'd1;
            ser_valid_next = !ser_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg <= 1'b0;
            ser_cnt_reg   <= 3'd0;
        end else begin
            ser_valid_reg <= ser_valid_next;
            ser_cnt_reg   <= ser_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ser_pix_reg <= ser_pix_next;
    end

    // Result word.
    assign m_valid = ser_valid_reg;

    always_comb begin
        m_data.pixel_color = ser_pix_reg[2:0];
        m_data.last_pixel  = ser_last;
    end

`ifndef SYNTHESIS
    // A cell line is never cut short: after a non-final pixel is taken,
    // another pixel of the same cell follows.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ser_valid_reg && m_ready && !ser_last) |=> ser_valid_reg)
        else $error("pixel stream ended before the eighth pixel");

    // Write words retire at the memory stage and never enter the compose stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && !s1_render) |=> !s2_valid_reg)
        else $error("write word reached the compose stage");

    // A composed line waiting for the serializer is not dropped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_valid_reg && !ser_load) |=> (s3_valid_reg && $stable(s3_pix_reg)))
        else $error("composed cell line lost while waiting");
`endif

endmodule
